// ===== rtl/core/ssps_pkg.sv =====
// ----------------------------------------------------------------------------
// ssps_pkg
// Shared types, operation codes and pot mapping helpers for the song step
// parameter sequencer.
// ----------------------------------------------------------------------------
package ssps_pkg;

  typedef enum logic [2:0] {
    OP_STORE   = 3'd0,
    OP_LOOP    = 3'd1,
    OP_RESTART = 3'd2,
    OP_ADVANCE = 3'd3,
    OP_APPLY   = 3'd4,
    OP_DIRECT  = 3'd5
  } op_e;

  localparam int unsigned POT_W      = 7;
  localparam int unsigned ROOT_STEPS = 12;
  localparam int unsigned ROOT_MAX   = 11;
  localparam int unsigned SCALE_KINDS = 8;
  localparam int unsigned SCALE_MAX  = 7;
  localparam int unsigned VEL_BIAS   = 64;

  typedef struct packed {
    logic [POT_W-1:0] pattern;
    logic [POT_W-1:0] root;
    logic [POT_W-1:0] scale;
    logic [POT_W-1:0] velocity;
  } pots_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } evs_cmd_t;

  typedef struct packed {
    logic rd_en;
    logic direct_wr;
    logic bcast;
  } mdt_cmd_t;

  function automatic logic [3:0] map_root(input logic [POT_W-1:0] p);
    logic [10:0] prod;
    logic [3:0]  r;
    prod = 11'(p) * 11'(ROOT_STEPS);
    r    = prod[10:7];
    return (r > 4'(ROOT_MAX)) ? 4'(ROOT_MAX) : r;
  endfunction

  function automatic logic [2:0] map_scale(input logic [POT_W-1:0] p);
    logic [9:0] prod;
    prod = 10'(p) * 10'(SCALE_KINDS);
    // product stays below 1024, so the top bits are already within 0..7
    return (prod[9:7] > 3'(SCALE_MAX)) ? 3'(SCALE_MAX) : prod[9:7];
  endfunction

  function automatic logic signed [POT_W-1:0] vel_offset(input logic [POT_W-1:0] p);
    return signed'(p - POT_W'(VEL_BIAS));
  endfunction

endpackage

// ===== rtl/core/ssps_event_store.sv =====
// ----------------------------------------------------------------------------
// ssps_event_store
// Step event memory: pots in a synchronous RAM, switch flags in flops so the
// store clears at reset and the loop length search sees all steps at once.
// ----------------------------------------------------------------------------
module ssps_event_store #(
  parameter int unsigned STEP_COUNT = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ssps_pkg::evs_cmd_t               cmd_i,
  input  logic [$clog2(STEP_COUNT)-1:0]    rd_addr_i,
  input  logic [$clog2(STEP_COUNT)-1:0]    wr_addr_i,
  input  logic                             wr_on_i,
  input  ssps_pkg::pots_t                  wr_pots_i,
  output logic                             rd_on_o,
  output ssps_pkg::pots_t                  rd_pots_o,
  output logic [$clog2(STEP_COUNT+1)-1:0]  loop_len_o
);

  localparam int unsigned LW = $clog2(STEP_COUNT + 1);

  ssps_pkg::pots_t        mem [STEP_COUNT];
  logic [STEP_COUNT-1:0]  on_q;
  logic                   rd_on_q;
  ssps_pkg::pots_t        rd_pots_q;
  logic [LW-1:0]          len;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= wr_pots_i;
    end
    if (cmd_i.rd_en) begin
      rd_pots_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q    <= '0;
      rd_on_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        on_q[wr_addr_i] <= wr_on_i;
      end
      if (cmd_i.rd_en) begin
        rd_on_q <= on_q[rd_addr_i];
      end
    end
  end

  // highest active step plus one, never below one
  always_comb begin
    len = LW'(1);
    for (int i = 0; i < STEP_COUNT; i++) begin
      if (on_q[i]) begin
        len = LW'(i + 1);
      end
    end
  end

  assign rd_on_o    = rd_on_q;
  assign rd_pots_o  = rd_pots_q;
  assign loop_len_o = len;

endmodule

// ===== rtl/core/ssps_mode_table.sv =====
// ----------------------------------------------------------------------------
// ssps_mode_table
// Per-mode pattern override and velocity offset. Direct writes go to a RAM;
// an apply is held as one broadcast entry that covers every mode above zero
// until that mode is written directly again.
// ----------------------------------------------------------------------------
module ssps_mode_table #(
  parameter int unsigned MODE_COUNT    = 15,
  parameter int unsigned PATTERN_COUNT = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ssps_pkg::mdt_cmd_t                   cmd_i,
  input  logic [$clog2(MODE_COUNT)-1:0]        rd_addr_i,
  input  logic [$clog2(MODE_COUNT)-1:0]        wr_addr_i,
  input  logic [$clog2(PATTERN_COUNT)-1:0]     wr_pat_i,
  input  logic signed [ssps_pkg::POT_W-1:0]    wr_off_i,
  output logic [$clog2(PATTERN_COUNT)-1:0]     q_pat_o,
  output logic                                 q_pres_o,
  output logic signed [ssps_pkg::POT_W-1:0]    q_off_o
);

  localparam int unsigned PW = $clog2(PATTERN_COUNT);

  typedef struct packed {
    logic [PW-1:0]                      pat;
    logic signed [ssps_pkg::POT_W-1:0]  off;
  } entry_t;

  entry_t                 mem [MODE_COUNT];
  entry_t                 rd_q;
  logic [MODE_COUNT-1:0]  direct_q;
  logic                   rd_direct_q;
  logic                   rd_nz_q;
  logic                   bcast_valid_q;
  entry_t                 bcast_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.direct_wr) begin
      mem[wr_addr_i] <= '{pat: wr_pat_i, off: wr_off_i};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direct_q      <= '0;
      rd_direct_q   <= 1'b0;
      rd_nz_q       <= 1'b0;
      bcast_valid_q <= 1'b0;
      bcast_q       <= '0;
    end else begin
      if (cmd_i.rd_en) begin
        rd_direct_q <= direct_q[rd_addr_i];
        rd_nz_q     <= (rd_addr_i != '0);
      end
      if (cmd_i.direct_wr) begin
        direct_q[wr_addr_i] <= 1'b1;
      end
      if (cmd_i.bcast) begin
        bcast_valid_q <= 1'b1;
        bcast_q       <= '{pat: wr_pat_i, off: wr_off_i};
        // mode zero keeps its own entry
        for (int i = 1; i < MODE_COUNT; i++) begin
          direct_q[i] <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (rd_direct_q) begin
      q_pat_o  = rd_q.pat;
      q_pres_o = 1'b1;
      q_off_o  = rd_q.off;
    end else if (rd_nz_q && bcast_valid_q) begin
      q_pat_o  = bcast_q.pat;
      q_pres_o = 1'b1;
      q_off_o  = bcast_q.off;
    end else begin
      q_pat_o  = '0;
      q_pres_o = 1'b0;
      q_off_o  = '0;
    end
  end

endmodule

// ===== rtl/core/song_step_parameter_sequencer.sv =====
// ----------------------------------------------------------------------------
// song_step_parameter_sequencer
// Song-mode step sequencer: event store, loop control, global scale and
// per-mode pattern overrides and velocity offsets, one result per command.
// ----------------------------------------------------------------------------
// A word is accepted, then executed: the accept cycle reads the event memory at
// the current step and the mode memory at the queried mode, and the execute
// cycle updates state, writes back and loads the result register. An advance
// that wraps the loop runs a subtract loop for the modulo in state ST_MOD.
// A result that is not taken holds the next command in its execute cycle.
// Reset clears the event switches at once; no clearing pass is needed.
module song_step_parameter_sequencer #(
  parameter int unsigned STEP_COUNT    = 16,
  parameter int unsigned MODE_COUNT    = 15,
  parameter int unsigned PATTERN_COUNT = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        op_i,
  input  logic [3:0]        step_index_i,
  input  logic              switch_on_i,
  input  logic [6:0]        pot_pattern_i,
  input  logic [6:0]        pot_root_i,
  input  logic [6:0]        pot_scale_i,
  input  logic [6:0]        pot_velocity_i,
  input  logic [3:0]        dest_mode_i,
  input  logic [3:0]        query_mode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        step_position_o,
  output logic [4:0]        loop_steps_o,
  output logic [3:0]        scale_root_o,
  output logic [2:0]        scale_kind_o,
  output logic [4:0]        pattern_choice_o,
  output logic              override_present_o,
  output logic signed [6:0] velocity_shift_o,
  output logic              target_rejected_o
);

  localparam int unsigned SW = $clog2(STEP_COUNT);
  localparam int unsigned LW = $clog2(STEP_COUNT + 1);
  localparam int unsigned MW = $clog2(MODE_COUNT);
  localparam int unsigned PW = $clog2(PATTERN_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOD
  } state_e;

  state_e                state_q, state_d;
  logic [2:0]            op_q, op_d;
  logic [3:0]            step_index_q, step_index_d;
  logic                  switch_on_q, switch_on_d;
  ssps_pkg::pots_t       pots_q, pots_d;
  logic [3:0]            dest_mode_q, dest_mode_d;
  logic [3:0]            query_mode_q, query_mode_d;
  logic [SW-1:0]         cur_q, cur_d;
  logic [LW-1:0]         loop_q, loop_d;
  logic [3:0]            root_q, root_d;
  logic [2:0]            scale_q, scale_d;
  logic [LW-1:0]         rem_q, rem_d;
  logic                  out_valid_q, out_valid_d;
  logic [3:0]            out_step_q, out_step_d;
  logic [4:0]            out_loop_q, out_loop_d;
  logic [3:0]            out_root_q, out_root_d;
  logic [2:0]            out_scale_q, out_scale_d;
  logic [4:0]            out_pat_q, out_pat_d;
  logic                  out_pres_q, out_pres_d;
  logic signed [6:0]     out_off_q, out_off_d;
  logic                  out_rej_q, out_rej_d;

  ssps_pkg::evs_cmd_t    evs_cmd;
  ssps_pkg::mdt_cmd_t    mdt_cmd;
  logic [SW-1:0]         evs_wr_addr;
  logic                  ev_rd_on;
  ssps_pkg::pots_t       ev_rd_pots;
  logic [LW-1:0]         ev_loop_len;
  logic [MW-1:0]         mdt_rd_addr;
  logic [MW-1:0]         mdt_wr_addr;
  logic [PW-1:0]         mt_pat;
  logic                  mt_pres;
  logic signed [6:0]     mt_off;

  ssps_pkg::pots_t       sel_pots;
  logic [13:0]           pat_prod;
  logic [6:0]            pat_raw;
  logic [PW-1:0]         pat_map;
  logic signed [6:0]     off_map;
  logic [31:0]           step_ext, tmode_ext, qmode_in_ext, qmode_ext;
  logic                  out_free, finish, rejected;
  logic [LW-1:0]         adv_sum;
  logic [PW-1:0]         res_pat;
  logic                  res_pres;
  logic signed [6:0]     res_off;
  logic [31:0]           cur_ext, loop_ext, pat_ext;

  assign step_ext     = 32'(step_index_q);
  assign tmode_ext    = 32'(dest_mode_q);
  assign qmode_ext    = 32'(query_mode_q);
  assign qmode_in_ext = 32'(query_mode_i);
  assign evs_wr_addr  = step_ext[SW-1:0];
  assign mdt_wr_addr  = tmode_ext[MW-1:0];
  assign mdt_rd_addr  = (qmode_in_ext < MODE_COUNT) ? qmode_in_ext[MW-1:0] : '0;

  // apply takes the stored event, direct takes the pots of the command word
  assign sel_pots = (op_q == ssps_pkg::OP_APPLY) ? ev_rd_pots : pots_q;
  assign pat_prod = 14'(sel_pots.pattern) * 14'(PATTERN_COUNT);
  assign pat_raw  = pat_prod[13:7];
  assign pat_map  = (pat_raw > 7'(PATTERN_COUNT - 1)) ? PW'(PATTERN_COUNT - 1)
                                                      : pat_raw[PW-1:0];
  assign off_map  = ssps_pkg::vel_offset(sel_pots.velocity);
  assign adv_sum  = LW'(cur_q) + LW'(1);
  assign out_free = !out_valid_q || out_ready_i;

  ssps_event_store #(
    .STEP_COUNT(STEP_COUNT)
  ) u_event_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (evs_cmd),
    .rd_addr_i  (cur_q),
    .wr_addr_i  (evs_wr_addr),
    .wr_on_i    (switch_on_q),
    .wr_pots_i  (pots_q),
    .rd_on_o    (ev_rd_on),
    .rd_pots_o  (ev_rd_pots),
    .loop_len_o (ev_loop_len)
  );

  ssps_mode_table #(
    .MODE_COUNT   (MODE_COUNT),
    .PATTERN_COUNT(PATTERN_COUNT)
  ) u_mode_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (mdt_cmd),
    .rd_addr_i (mdt_rd_addr),
    .wr_addr_i (mdt_wr_addr),
    .wr_pat_i  (pat_map),
    .wr_off_i  (off_map),
    .q_pat_o   (mt_pat),
    .q_pres_o  (mt_pres),
    .q_off_o   (mt_off)
  );

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    step_index_d  = step_index_q;
    switch_on_d   = switch_on_q;
    pots_d        = pots_q;
    dest_mode_d   = dest_mode_q;
    query_mode_d  = query_mode_q;
    cur_d         = cur_q;
    loop_d        = loop_q;
    root_d        = root_q;
    scale_d       = scale_q;
    rem_d         = rem_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_step_d    = out_step_q;
    out_loop_d    = out_loop_q;
    out_root_d    = out_root_q;
    out_scale_d   = out_scale_q;
    out_pat_d     = out_pat_q;
    out_pres_d    = out_pres_q;
    out_off_d     = out_off_q;
    out_rej_d     = out_rej_q;
    evs_cmd       = '0;
    mdt_cmd       = '0;
    finish        = 1'b0;
    rejected      = 1'b0;
    res_pat       = '0;
    res_pres      = 1'b0;
    res_off       = '0;
    cur_ext       = '0;
    loop_ext      = '0;
    pat_ext       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d          = op_i;
          step_index_d  = step_index_i;
          switch_on_d   = switch_on_i;
          pots_d        = '{pattern: pot_pattern_i, root: pot_root_i,
                            scale: pot_scale_i, velocity: pot_velocity_i};
          dest_mode_d   = dest_mode_i;
          query_mode_d  = query_mode_i;
          evs_cmd.rd_en = 1'b1;
          mdt_cmd.rd_en = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          finish = 1'b1;
          unique case (op_q)
            ssps_pkg::OP_STORE: begin
              evs_cmd.wr_en = (step_ext < STEP_COUNT);
            end
            ssps_pkg::OP_LOOP: begin
              loop_d = ev_loop_len;
            end
            ssps_pkg::OP_RESTART: begin
              cur_d = '0;
            end
            ssps_pkg::OP_ADVANCE: begin
              if (adv_sum < loop_q) begin
                cur_d = adv_sum[SW-1:0];
              end else begin
                // wrap, finish the modulo by repeated subtraction
                finish  = 1'b0;
                rem_d   = adv_sum - loop_q;
                state_d = ST_MOD;
              end
            end
            ssps_pkg::OP_APPLY: begin
              if (ev_rd_on) begin
                mdt_cmd.bcast = 1'b1;
                root_d        = ssps_pkg::map_root(sel_pots.root);
                scale_d       = ssps_pkg::map_scale(sel_pots.scale);
              end
            end
            ssps_pkg::OP_DIRECT: begin
              if (tmode_ext >= MODE_COUNT) begin
                rejected = 1'b1;
              end else if (switch_on_q) begin
                mdt_cmd.direct_wr = 1'b1;
                root_d            = ssps_pkg::map_root(sel_pots.root);
                scale_d           = ssps_pkg::map_scale(sel_pots.scale);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MOD: begin
        if (rem_q < loop_q) begin
          if (out_free) begin
            cur_d  = rem_q[SW-1:0];
            finish = 1'b1;
          end
        end else begin
          rem_d = rem_q - loop_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      state_d = ST_IDLE;
      // queried mode after this word, forwarding its own write
      if (qmode_ext < MODE_COUNT) begin
        if ((mdt_cmd.direct_wr && (dest_mode_q == query_mode_q)) ||
            (mdt_cmd.bcast && (query_mode_q != '0))) begin
          res_pat  = pat_map;
          res_pres = 1'b1;
          res_off  = off_map;
        end else begin
          res_pat  = mt_pat;
          res_pres = mt_pres;
          res_off  = mt_off;
        end
      end
      cur_ext     = 32'(cur_d);
      loop_ext    = 32'(loop_d);
      pat_ext     = 32'(res_pat);
      out_valid_d = 1'b1;
      out_step_d  = cur_ext[3:0];
      out_loop_d  = loop_ext[4:0];
      out_root_d  = root_d;
      out_scale_d = scale_d;
      out_pat_d   = pat_ext[4:0];
      out_pres_d  = res_pres;
      out_off_d   = res_off;
      out_rej_d   = rejected;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= '0;
      step_index_q  <= '0;
      switch_on_q   <= 1'b0;
      pots_q        <= '0;
      dest_mode_q   <= '0;
      query_mode_q  <= '0;
      cur_q         <= '0;
      loop_q        <= LW'(STEP_COUNT);
      root_q        <= '0;
      scale_q       <= '0;
      rem_q         <= '0;
      out_valid_q   <= 1'b0;
      out_step_q    <= '0;
      out_loop_q    <= '0;
      out_root_q    <= '0;
      out_scale_q   <= '0;
      out_pat_q     <= '0;
      out_pres_q    <= 1'b0;
      out_off_q     <= '0;
      out_rej_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      op_q          <= op_d;
      step_index_q  <= step_index_d;
      switch_on_q   <= switch_on_d;
      pots_q        <= pots_d;
      dest_mode_q   <= dest_mode_d;
      query_mode_q  <= query_mode_d;
      cur_q         <= cur_d;
      loop_q        <= loop_d;
      root_q        <= root_d;
      scale_q       <= scale_d;
      rem_q         <= rem_d;
      out_valid_q   <= out_valid_d;
      out_step_q    <= out_step_d;
      out_loop_q    <= out_loop_d;
      out_root_q    <= out_root_d;
      out_scale_q   <= out_scale_d;
      out_pat_q     <= out_pat_d;
      out_pres_q    <= out_pres_d;
      out_off_q     <= out_off_d;
      out_rej_q     <= out_rej_d;
    end
  end

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign step_position_o    = out_step_q;
  assign loop_steps_o       = out_loop_q;
  assign scale_root_o       = out_root_q;
  assign scale_kind_o       = out_scale_q;
  assign pattern_choice_o   = out_pat_q;
  assign override_present_o = out_pres_q;
  assign velocity_shift_o   = out_off_q;
  assign target_rejected_o  = out_rej_q;

  // one word in flight: an accepted word blocks the next until it is finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("word accepted while another is in flight");

  // a direct write and a broadcast never hit the mode table together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mdt_cmd.direct_wr, mdt_cmd.bcast}))
    else $error("mode table direct write and broadcast together");

  // a zero loop length would hang the modulo loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |-> (loop_q != '0))
    else $error("modulo loop running with zero loop length");

  // a result is loaded only when the previous one is gone or taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && (state_q != ST_IDLE)) |=> $stable(out_step_q))
    else $error("pending result overwritten");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the song step parameter sequencer. A driver feeds
// command words from a queue, a shadow of the sequencer state predicts every
// report, and a monitor compares each report field by field. Runs through
// directed corner cases, then random song passes under several idling mixes
// and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEP_COUNT    = 16;
  localparam int unsigned MODE_COUNT    = 15;
  localparam int unsigned PATTERN_COUNT = 32;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_WORDS   = 110;

  // op codes the block does not implement, only reports on
  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0]      op;
    logic [3:0]      step_index;
    logic            switch_on;
    ssps_pkg::pots_t pots;
    logic [3:0]      dest_mode;
    logic [3:0]      query_mode;
  } cmd_t;

  typedef struct packed {
    logic [3:0] step;
    logic [4:0] loop;
    logic [3:0] root;
    logic [2:0] kind;
    logic [4:0] pattern;
    logic       present;
    logic [6:0] shift;
    logic       rejected;
  } report_t;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  cmd_t              bus_cmd = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [3:0]        step_position_o;
  logic [4:0]        loop_steps_o;
  logic [3:0]        scale_root_o;
  logic [2:0]        scale_kind_o;
  logic [4:0]        pattern_choice_o;
  logic              override_present_o;
  logic signed [6:0] velocity_shift_o;
  logic              target_rejected_o;

  cmd_t    command_queue[$];
  report_t pending_reports[$];
  report_t want_report;
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  logic    hold_phase = 1'b0;
  int unsigned hold_count = 0;
  int unsigned words_queued = 0;

  // sequencer shadow
  logic            step_on[STEP_COUNT];
  ssps_pkg::pots_t step_pots[STEP_COUNT];
  int unsigned     cur_step = 0;
  int unsigned     loop_len = STEP_COUNT;
  int unsigned     root_now = 0;
  int unsigned     kind_now = 0;
  logic            mode_has[MODE_COUNT];
  int unsigned     mode_pat[MODE_COUNT];
  int              mode_shift[MODE_COUNT];

  // switches as the generator left them, to build loops of known length
  logic        gen_sw[STEP_COUNT];

  always #5 clk_i = ~clk_i;

  song_step_parameter_sequencer #(
    .STEP_COUNT   (STEP_COUNT),
    .MODE_COUNT   (MODE_COUNT),
    .PATTERN_COUNT(PATTERN_COUNT)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (bus_cmd.op),
    .step_index_i      (bus_cmd.step_index),
    .switch_on_i       (bus_cmd.switch_on),
    .pot_pattern_i     (bus_cmd.pots.pattern),
    .pot_root_i        (bus_cmd.pots.root),
    .pot_scale_i       (bus_cmd.pots.scale),
    .pot_velocity_i    (bus_cmd.pots.velocity),
    .dest_mode_i       (bus_cmd.dest_mode),
    .query_mode_i      (bus_cmd.query_mode),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .step_position_o   (step_position_o),
    .loop_steps_o      (loop_steps_o),
    .scale_root_o      (scale_root_o),
    .scale_kind_o      (scale_kind_o),
    .pattern_choice_o  (pattern_choice_o),
    .override_present_o(override_present_o),
    .velocity_shift_o  (velocity_shift_o),
    .target_rejected_o (target_rejected_o)
  );

  function automatic int unsigned pattern_of(logic [6:0] p);
    int unsigned v;
    v = (int'(p) * PATTERN_COUNT) / 128;
    return (v > PATTERN_COUNT - 1) ? PATTERN_COUNT - 1 : v;
  endfunction

  function automatic int unsigned root_of(logic [6:0] p);
    int unsigned v;
    v = (int'(p) * 12) / 128;
    return (v > 11) ? 11 : v;
  endfunction

  function automatic int unsigned kind_of(logic [6:0] p);
    int unsigned v;
    v = (int'(p) * 8) / 128;
    return (v > 7) ? 7 : v;
  endfunction

  task automatic predict_report(cmd_t c);
    report_t         r;
    ssps_pkg::pots_t ep;
    int unsigned     top;
    r = '0;
    unique case (c.op)
      ssps_pkg::OP_STORE: begin
        if (c.step_index < STEP_COUNT) begin
          step_on[c.step_index]   = c.switch_on;
          step_pots[c.step_index] = c.pots;
        end
      end
      ssps_pkg::OP_LOOP: begin
        top = 0;
        for (int i = 0; i < STEP_COUNT; i++) begin
          if (step_on[i]) top = i + 1;
        end
        loop_len = (top < 1) ? 1 : top;
      end
      ssps_pkg::OP_RESTART: cur_step = 0;
      ssps_pkg::OP_ADVANCE: cur_step = (cur_step + 1) % loop_len;
      ssps_pkg::OP_APPLY: begin
        if (cur_step < STEP_COUNT && step_on[cur_step]) begin
          ep = step_pots[cur_step];
          // mode 0 is left alone by a broadcast
          for (int m = 1; m < MODE_COUNT; m++) begin
            mode_has[m]   = 1'b1;
            mode_pat[m]   = pattern_of(ep.pattern);
            mode_shift[m] = int'(ep.velocity) - 64;
          end
          root_now = root_of(ep.root);
          kind_now = kind_of(ep.scale);
        end
      end
      ssps_pkg::OP_DIRECT: begin
        if (c.dest_mode >= MODE_COUNT) begin
          r.rejected = 1'b1;
        end else if (c.switch_on) begin
          mode_has[c.dest_mode]   = 1'b1;
          mode_pat[c.dest_mode]   = pattern_of(c.pots.pattern);
          mode_shift[c.dest_mode] = int'(c.pots.velocity) - 64;
          root_now = root_of(c.pots.root);
          kind_now = kind_of(c.pots.scale);
        end
      end
      default: ;
    endcase
    if (c.query_mode < MODE_COUNT) begin
      if (mode_has[c.query_mode]) begin
        r.pattern = 5'(mode_pat[c.query_mode]);
        r.present = 1'b1;
      end
      r.shift = 7'(mode_shift[c.query_mode]);
    end
    r.step = 4'(cur_step);
    r.loop = 5'(loop_len);
    r.root = 4'(root_now);
    r.kind = 3'(kind_now);
    pending_reports.push_back(r);
  endtask

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // driver: predicts on acceptance, then offers the next word or idles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_report(bus_cmd);
      if (!in_valid_i || in_ready_o) begin
        if (command_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          bus_cmd    <= command_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and output back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $error("report word with no command outstanding");
        mismatches++;
      end else begin
        want_report = pending_reports.pop_front();
        check_field("step_position", want_report.step, step_position_o);
        check_field("loop_steps", want_report.loop, loop_steps_o);
        check_field("scale_root", want_report.root, scale_root_o);
        check_field("scale_kind", want_report.kind, scale_kind_o);
        check_field("pattern_choice", want_report.pattern, pattern_choice_o);
        check_field("override_present", want_report.present, override_present_o);
        check_field("velocity_shift", $signed(want_report.shift), velocity_shift_o);
        check_field("target_rejected", want_report.rejected, target_rejected_o);
      end
    end
    if (hold_phase && hold_count < HOLD_CYCLES) begin
      hold_count  <= hold_count + 1;
      out_ready_i <= 1'b0;
    end else begin
      if (!hold_phase) hold_count <= 0;
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic enqueue(cmd_t c);
    if (c.op == ssps_pkg::OP_STORE) gen_sw[c.step_index] = c.switch_on;
    command_queue.push_back(c);
    words_queued++;
  endtask

  function automatic cmd_t random_cmd(logic [2:0] op);
    cmd_t c;
    c.op             = op;
    c.step_index     = 4'($urandom_range(15));
    c.switch_on      = 1'($urandom_range(1));
    c.pots.pattern   = 7'($urandom_range(127));
    c.pots.root      = 7'($urandom_range(127));
    c.pots.scale     = 7'($urandom_range(127));
    c.pots.velocity  = 7'($urandom_range(127));
    c.dest_mode      = 4'($urandom_range(15));
    c.query_mode     = 4'($urandom_range(15));
    return c;
  endfunction

  function automatic cmd_t fixed_cmd(logic [2:0] op, int idx, bit sw, int pot, int tm, int qm);
    cmd_t c;
    c.op          = op;
    c.step_index  = 4'(idx);
    c.switch_on   = sw;
    c.pots        = {4{7'(pot)}};
    c.dest_mode   = 4'(tm);
    c.query_mode  = 4'(qm);
    return c;
  endfunction

  // one pass of a song: trim the loop to a chosen length, then play it
  task automatic queue_song();
    int unsigned len;
    int unsigned beats;
    cmd_t        c;
    len = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
    for (int s = len; s < STEP_COUNT; s++) begin
      if (gen_sw[s]) begin
        c = random_cmd(ssps_pkg::OP_STORE);
        c.step_index = 4'(s);
        c.switch_on  = 1'b0;
        enqueue(c);
      end
    end
    repeat ($urandom_range(1, 3)) begin
      c = random_cmd(ssps_pkg::OP_STORE);
      c.step_index = 4'($urandom_range(len - 1));
      c.switch_on  = ($urandom_range(3) != 0);
      enqueue(c);
    end
    c = random_cmd(ssps_pkg::OP_STORE);
    c.step_index = 4'(len - 1);
    c.switch_on  = 1'b1;
    enqueue(c);
    enqueue(random_cmd(ssps_pkg::OP_LOOP));
    enqueue(random_cmd(ssps_pkg::OP_RESTART));
    beats = $urandom_range(len, 2 * len + 2);
    repeat (beats) begin
      enqueue(random_cmd(ssps_pkg::OP_APPLY));
      enqueue(random_cmd(ssps_pkg::OP_ADVANCE));
      if ($urandom_range(5) == 0) enqueue(random_cmd(ssps_pkg::OP_DIRECT));
    end
  endtask

  task automatic drain();
    while (command_queue.size() != 0 || in_valid_i || pending_reports.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_phase(int s_pct, int r_pct, int unsigned count);
    int unsigned target;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    target = words_queued + count;
    while (words_queued < target) begin
      if ($urandom_range(99) < 70) begin
        queue_song();
      end else begin
        repeat (3) enqueue(random_cmd(3'($urandom_range(7))));
      end
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < STEP_COUNT; i++) begin
      step_on[i]   = 1'b0;
      step_pots[i] = '0;
      gen_sw[i]    = 1'b0;
    end
    for (int m = 0; m < MODE_COUNT; m++) begin
      mode_has[m]   = 1'b0;
      mode_pat[m]   = 0;
      mode_shift[m] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed corners, no idling
    enqueue(fixed_cmd(OP_UNUSED_HI, 0, 1'b0, 0, 0, 15));
    enqueue(fixed_cmd(OP_UNUSED_LO, 15, 1'b1, 127, 15, 0));
    enqueue(fixed_cmd(ssps_pkg::OP_LOOP, 0, 1'b0, 0, 0, 1));     // empty store clamps to one
    enqueue(fixed_cmd(ssps_pkg::OP_ADVANCE, 0, 1'b0, 0, 0, 2));
    enqueue(fixed_cmd(ssps_pkg::OP_STORE, 15, 1'b1, 127, 0, 3));
    enqueue(fixed_cmd(ssps_pkg::OP_STORE, 0, 1'b1, 0, 0, 4));
    enqueue(fixed_cmd(ssps_pkg::OP_LOOP, 0, 1'b0, 0, 0, 5));
    enqueue(fixed_cmd(ssps_pkg::OP_APPLY, 0, 1'b0, 0, 0, 1));
    enqueue(fixed_cmd(ssps_pkg::OP_ADVANCE, 0, 1'b0, 0, 0, 0));
    enqueue(fixed_cmd(ssps_pkg::OP_APPLY, 0, 1'b1, 127, 0, 14));   // step switch off
    enqueue(fixed_cmd(ssps_pkg::OP_DIRECT, 0, 1'b1, 127, 15, 15)); // bad target
    enqueue(fixed_cmd(ssps_pkg::OP_DIRECT, 0, 1'b0, 127, 15, 0));
    enqueue(fixed_cmd(ssps_pkg::OP_DIRECT, 0, 1'b0, 127, 0, 0));   // switch off, no change
    enqueue(fixed_cmd(ssps_pkg::OP_DIRECT, 0, 1'b1, 127, 0, 0));
    enqueue(fixed_cmd(ssps_pkg::OP_DIRECT, 0, 1'b1, 64, 14, 14));
    enqueue(fixed_cmd(ssps_pkg::OP_RESTART, 0, 1'b0, 0, 0, 7));
    enqueue(fixed_cmd(ssps_pkg::OP_STORE, 15, 1'b0, 0, 0, 8));
    enqueue(fixed_cmd(ssps_pkg::OP_STORE, 3, 1'b1, 100, 0, 9));
    enqueue(fixed_cmd(ssps_pkg::OP_LOOP, 0, 1'b0, 0, 0, 10));
    repeat (4) enqueue(fixed_cmd(ssps_pkg::OP_ADVANCE, 0, 1'b0, 0, 0, 11));   // wraps
    repeat (3) enqueue(fixed_cmd(ssps_pkg::OP_ADVANCE, 0, 1'b0, 0, 0, 12));
    enqueue(fixed_cmd(ssps_pkg::OP_APPLY, 0, 1'b0, 0, 0, 13));
    drain();

    run_phase(0, 0, PHASE_WORDS);
    run_phase(70, 0, PHASE_WORDS);
    run_phase(0, 70, PHASE_WORDS);
    run_phase(22, 22, PHASE_WORDS);

    // long output hold-off while words keep coming
    hold_phase = 1'b1;
    run_phase(0, 0, 60);
    hold_phase = 1'b0;

    run_phase(22, 22, PHASE_WORDS);

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
